### src/qnps_pkg.sv
// shared types and codes for the quadrant nearest pixel search unit
// no dependencies
package qnps_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] CFG_COL_COUNT    = 2'd1;
    localparam logic [1:0] CFG_MAX_DISTANCE = 2'd2;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [16:0] SQ_MAX = 17'd131071;

    typedef struct packed {
        logic       operation;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] pixel_value;
        logic [1:0] quadrant;
    } qnps_in_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  found_row;
        logic [7:0]  found_col;
        logic [7:0]  found_value;
        logic [16:0] squared_distance;
    } qnps_out_t;

    // one scan position sent to the memory and the compare pipeline
    typedef struct packed {
        logic       vld;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] abs_a;
        logic [7:0] abs_b;
    } qnps_issue_t;

    typedef struct packed {
        logic idle;
        logic done;
    } qnps_seq_stat_t;

    typedef struct packed {
        logic        hit;
        logic [16:0] sq_dist;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [7:0]  value;
    } qnps_best_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_DRAIN,
        SEQ_DONE
    } qnps_seq_state_t;

endpackage

### src/qnps_image_mem.sv
// image store: one write port, one read port, registered read data
// depends on nothing
module qnps_image_mem #(
    parameter int AW = 16
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [0:(1 << AW) - 1];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### src/qnps_scan_seq.sv
// ring walker: steps through the two segments of each ring and issues reads
// depends on qnps_pkg
module qnps_scan_seq (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [1:0]               quad_in,
    input  logic [7:0]               cr_in,
    input  logic [7:0]               cc_in,
    input  logic [8:0]               nr,
    input  logic [8:0]               nc,
    input  logic [7:0]               md,
    input  logic                     hit,
    input  logic                     out_free,
    output qnps_pkg::qnps_issue_t    issue,
    output qnps_pkg::qnps_seq_stat_t stat
);
    import qnps_pkg::*;

    typedef struct packed {
        logic signed [8:0] a;
        logic signed [8:0] b;
    } offs_t;

    qnps_seq_state_t state_reg, state_next;
    logic [1:0]  quad_reg;
    logic [7:0]  cr_reg, cc_reg;
    logic [7:0]  ring_reg;
    logic        seg_reg;
    logic [7:0]  cnt_reg;
    logic        drain_reg;
    offs_t       off_reg;

    logic              seg_end;
    logic              ring_stop;
    logic signed [9:0] row_s, col_s;
    logic              in_range;
    logic [8:0]        neg_a, neg_b;
    offs_t             step;

    // first offset of a segment, relative to the centre
    function automatic offs_t seg_start(input logic [1:0] q, input logic s,
                                        input logic [7:0] d);
        logic signed [8:0] dp, dn;
        offs_t o;
        dp = $signed({1'b0, d});
        dn = -dp;
        case (q)
            QUAD_0:  o = s ? offs_t'{a: dn, b: 9'sd0} : offs_t'{a: dn, b: dn};
            QUAD_1:  o = s ? offs_t'{a: 9'sd0, b: dn} : offs_t'{a: dp, b: dn};
            QUAD_2:  o = s ? offs_t'{a: dp, b: 9'sd0} : offs_t'{a: dp, b: dp};
            QUAD_3:  o = s ? offs_t'{a: 9'sd0, b: dp} : offs_t'{a: dn, b: dp};
            default: o = offs_t'{a: 9'sd0, b: 9'sd0};
        endcase
        return o;
    endfunction

    function automatic offs_t seg_step(input logic [1:0] q, input logic s);
        offs_t o;
        case (q)
            QUAD_0:  o = s ? offs_t'{a: 9'sd0, b: -9'sd1} : offs_t'{a: 9'sd1, b: 9'sd0};
            QUAD_1:  o = s ? offs_t'{a: 9'sd1, b: 9'sd0} : offs_t'{a: 9'sd0, b: 9'sd1};
            QUAD_2:  o = s ? offs_t'{a: 9'sd0, b: 9'sd1} : offs_t'{a: -9'sd1, b: 9'sd0};
            QUAD_3:  o = s ? offs_t'{a: -9'sd1, b: 9'sd0} : offs_t'{a: 9'sd0, b: -9'sd1};
            default: o = offs_t'{a: 9'sd0, b: 9'sd0};
        endcase
        return o;
    endfunction

    assign seg_end   = (cnt_reg == 8'(ring_reg - 8'd1));
    assign ring_stop = hit || (ring_reg == md);
    assign step      = seg_step(quad_reg, seg_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (start) begin
                    state_next = (md == 8'd0) ? SEQ_DONE : SEQ_SCAN;
                end
            end
            SEQ_SCAN: begin
                if (seg_reg && seg_end) begin
                    state_next = SEQ_DRAIN;
                end
            end
            SEQ_DRAIN: begin
                // wait for the last compare to pass the read and best registers
                if (drain_reg) begin
                    state_next = ring_stop ? SEQ_DONE : SEQ_SCAN;
                end
            end
            SEQ_DONE: begin
                if (out_free) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // walker registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            SEQ_IDLE: begin
                if (start) begin
                    quad_reg <= quad_in;
                    cr_reg   <= cr_in;
                    cc_reg   <= cc_in;
                    ring_reg <= 8'd1;
                    seg_reg  <= 1'b0;
                    cnt_reg  <= 8'd0;
                    off_reg  <= seg_start(quad_in, 1'b0, 8'd1);
                end
            end
            SEQ_SCAN: begin
                if (seg_end) begin
                    cnt_reg <= 8'd0;
                    if (!seg_reg) begin
                        seg_reg <= 1'b1;
                        off_reg <= seg_start(quad_reg, 1'b1, ring_reg);
                    end else begin
                        drain_reg <= 1'b0;
                    end
                end else begin
                    cnt_reg <= cnt_reg + 8'd1;
                    off_reg <= '{a: off_reg.a + step.a, b: off_reg.b + step.b};
                end
            end
            SEQ_DRAIN: begin
                drain_reg <= 1'b1;
                if (drain_reg && !ring_stop) begin
                    ring_reg <= ring_reg + 8'd1;
                    seg_reg  <= 1'b0;
                    off_reg  <= seg_start(quad_reg, 1'b0, 8'(ring_reg + 8'd1));
                end
            end
            default: ;
        endcase
    end

    // position in image coordinates and bounds check
    assign row_s    = $signed({2'b00, cr_reg}) + {off_reg.a[8], off_reg.a};
    assign col_s    = $signed({2'b00, cc_reg}) + {off_reg.b[8], off_reg.b};
    assign in_range = !row_s[9] && !col_s[9] && (row_s[8:0] < nr) && (col_s[8:0] < nc);
    assign neg_a    = 9'(-off_reg.a);
    assign neg_b    = 9'(-off_reg.b);

    // outputs
    always_comb begin
        issue.vld   = (state_reg == SEQ_SCAN) && in_range;
        issue.row   = row_s[7:0];
        issue.col   = col_s[7:0];
        issue.abs_a = off_reg.a[8] ? neg_a[7:0] : off_reg.a[7:0];
        issue.abs_b = off_reg.b[8] ? neg_b[7:0] : off_reg.b[7:0];
        stat.idle   = (state_reg == SEQ_IDLE);
        stat.done   = (state_reg == SEQ_DONE);
    end
endmodule

### src/qnps_best_track.sv
// compare pipeline: squares the offsets beside the memory read, then keeps
// the closest nonzero pixel; depends on qnps_pkg
module qnps_best_track (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear,
    input  qnps_pkg::qnps_issue_t issue,
    input  logic [7:0]            rd_data,
    output qnps_pkg::qnps_best_t  best
);
    import qnps_pkg::*;

    logic        p_vld_reg;
    logic [7:0]  p_row_reg, p_col_reg;
    logic [15:0] p_asq_reg, p_bsq_reg;
    qnps_best_t  best_reg;
    logic [16:0] d2;
    logic        take;

    // stage 1 runs in step with the memory read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
        end else begin
            p_vld_reg <= issue.vld;
        end
    end

    always_ff @(posedge aclk) begin
        p_row_reg <= issue.row;
        p_col_reg <= issue.col;
        p_asq_reg <= 16'(issue.abs_a) * 16'(issue.abs_a);
        p_bsq_reg <= 16'(issue.abs_b) * 16'(issue.abs_b);
    end

    assign d2   = {1'b0, p_asq_reg} + {1'b0, p_bsq_reg};
    // strict compare keeps the first of equal distances
    assign take = p_vld_reg && (rd_data != 8'd0)
                  && (!best_reg.hit || (d2 < best_reg.sq_dist));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg.hit <= 1'b0;
        end else if (clear) begin
            best_reg.hit <= 1'b0;
        end else if (take) begin
            best_reg.hit <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_reg.sq_dist <= d2;
            best_reg.row     <= p_row_reg;
            best_reg.col     <= p_col_reg;
            best_reg.value   <= rd_data;
        end
    end

    assign best = best_reg;
endmodule

### src/quadrant_nearest_pixel_search_unit.sv
// top level of the quadrant nearest pixel search unit
// depends on qnps_pkg, qnps_image_mem, qnps_scan_seq, qnps_best_track
//
//  channel  ports                               word
//  input    s_valid s_ready s_data              load pixel or search query
//  result   m_valid m_ready m_data              one per query, none per load
//  config   cfg_valid cfg_ready cfg_index/data  register write, always ready
//
// a load writes one pixel into the image store. a query walks the rings
// outward until a hit or the ring at max_distance: at most one image read
// per ring position through the single read port, plus a drain after each
// ring to let the compare pipeline settle.
// synchronous active-low reset; the image store is not cleared.
// input is held off while a query runs; the finishing cycle repeats while an
// earlier result still waits on m_ready. a finished result waits in the
// output register and the next word is taken meanwhile.
module quadrant_nearest_pixel_search_unit #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  qnps_pkg::qnps_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output qnps_pkg::qnps_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_data
);
    import qnps_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int LIM_R = (MAX_ROWS > 511) ? 511 : MAX_ROWS;
    localparam int LIM_C = (MAX_COLS > 511) ? 511 : MAX_COLS;

    logic [8:0]     row_count_reg, col_count_reg;
    logic [7:0]     max_distance_reg;
    logic [8:0]     nr, nc;
    logic           s_fire, start, load_en;
    logic [15:0]    md_sq;
    logic [17:0]    miss_full;
    logic [16:0]    miss_reg;
    logic           out_free, out_load;
    logic           m_valid_reg, m_valid_next;
    qnps_out_t      m_data_reg;
    qnps_issue_t    issue;
    qnps_seq_stat_t stat;
    qnps_best_t     best;
    logic [7:0]     rd_data;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= 9'd256;
            col_count_reg    <= 9'd256;
            max_distance_reg <= 8'd16;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                CFG_COL_COUNT:    col_count_reg    <= cfg_data;
                CFG_MAX_DISTANCE: max_distance_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign nr = (int'(row_count_reg) > LIM_R) ? 9'(LIM_R) : row_count_reg;
    assign nc = (int'(col_count_reg) > LIM_C) ? 9'(LIM_C) : col_count_reg;

    // input side
    assign s_ready = stat.idle;
    assign s_fire  = s_valid && s_ready;
    assign start   = s_fire && (s_data.operation == OP_QUERY);
    assign load_en = s_fire && (s_data.operation == OP_LOAD)
                     && (int'(s_data.row) < MAX_ROWS) && (int'(s_data.col) < MAX_COLS);

    // miss distance, 4*max_distance^2 saturated
    assign md_sq     = 16'(max_distance_reg) * 16'(max_distance_reg);
    assign miss_full = {md_sq, 2'b00};

    always_ff @(posedge aclk) begin
        if (start) begin
            miss_reg <= miss_full[17] ? SQ_MAX : miss_full[16:0];
        end
    end

    qnps_image_mem #(
        .AW(AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (load_en),
        .wr_addr ({RW'(s_data.row), CW'(s_data.col)}),
        .wr_data (s_data.pixel_value),
        .rd_en   (issue.vld),
        .rd_addr ({RW'(issue.row), CW'(issue.col)}),
        .rd_data (rd_data)
    );

    qnps_scan_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .quad_in  (s_data.quadrant),
        .cr_in    (s_data.row),
        .cc_in    (s_data.col),
        .nr       (nr),
        .nc       (nc),
        .md       (max_distance_reg),
        .hit      (best.hit),
        .out_free (out_free),
        .issue    (issue),
        .stat     (stat)
    );

    qnps_best_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (start),
        .issue   (issue),
        .rd_data (rd_data),
        .best    (best)
    );

    // output register
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = stat.done && out_free;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (best.hit) begin
                m_data_reg <= '{found: 1'b1, found_row: best.row, found_col: best.col,
                                found_value: best.value, squared_distance: best.sq_dist};
            end else begin
                m_data_reg <= '{found: 1'b0, found_row: 8'd0, found_col: 8'd0,
                                found_value: 8'd0, squared_distance: miss_reg};
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    a_found_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |->
            (m_data.squared_distance != 17'd0) && (m_data.squared_distance <= 17'd130050))
        else $error("found word with impossible distance");

    a_miss_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |->
            (m_data.found_row == 8'd0) && (m_data.found_col == 8'd0)
            && (m_data.found_value == 8'd0))
        else $error("miss word carries a position");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.operation == OP_QUERY) |=> !s_ready)
        else $error("input taken while a query starts");

    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        issue.vld |-> !s_ready && !stat.done)
        else $error("image read outside a scan");
endmodule
